// ===== hw/rtl/aho_pkg.sv =====
// Package for the additive harmonic oscillator: constants, command and status types,
// and the elaboration-time functions that build the sine table and the exponent factors.
// No dependencies.
`default_nettype none

package aho_pkg;

    localparam int MAX_HARMONICS_DEF = 64;
    localparam int SINE_ENTRIES_DEF  = 4096;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int IDX_W     = 8;
    localparam int STEP_W    = 5;
    localparam int LOG_LAST  = 15;
    localparam int POW_LAST  = 16;
    localparam int DIV_LAST  = 16;
    localparam int EF_COUNT  = 17;

    localparam logic [1:0] CFG_HARMONIC_COUNT = 2'd0;
    localparam logic [1:0] CFG_HARMONIC_MODE  = 2'd1;
    localparam logic [1:0] CFG_FALLOFF        = 2'd2;

    localparam logic [1:0] MODE_ALL  = 2'd0;
    localparam logic [1:0] MODE_ODD  = 2'd1;
    localparam logic [1:0] MODE_EVEN = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_ITEM,
        OP_RC_CLEAR,
        OP_RAW_DIRECT,
        OP_LOG_INIT,
        OP_LOG_STEP,
        OP_VMUL,
        OP_POW_STEP,
        OP_POW_FIN,
        OP_NORM_RD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_NORM_WR,
        OP_SUM_START,
        OP_SUM_ISSUE,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [IDX_W-1:0]    idx;
        logic [STEP_W-1:0]   step;
    } t_dp_cmd;

    typedef struct packed {
        logic direct;
        logic last;
        logic pipe_busy;
    } t_dp_status;

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned vv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        vv   = v;
        for (int n = 0; n < 32; n++) begin
            if (vv >= res + bitv) begin
                vv  = vv - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [30:0] ef_q30(input int j);
        longint unsigned e;
        e = Q30_ONE >> 1;
        for (int n = 0; n < j; n++) begin
            e = isqrt64(e << 30);
        end
        return e[30:0];
    endfunction

    function automatic logic signed [15:0] sine_q15(input longint unsigned t);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        longint unsigned q;
        quad = t >> 30;
        r    = t & 64'h3FFF_FFFF;
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        s  = Q30_ONE - x2 / 110;
        s  = Q30_ONE - ((x2 * s) >> 30) / 72;
        s  = Q30_ONE - ((x2 * s) >> 30) / 42;
        s  = Q30_ONE - ((x2 * s) >> 30) / 20;
        s  = Q30_ONE - ((x2 * s) >> 30) / 6;
        s  = (x * s) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return quad[1] ? 16'(64'd0 - q) : 16'(q);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aho_ctrl.sv =====
// Controller of the additive harmonic oscillator: sequences the amplitude recompute,
// the harmonic sum and the output register. Depends on aho_pkg.
`default_nettype none

module aho_ctrl
    import aho_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_cfg_touch,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_st,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RC_CLEAR,
        S_RC_RAW,
        S_LOG_INIT,
        S_LOG_STEP,
        S_VMUL,
        S_POW_STEP,
        S_POW_FIN,
        S_NORM_RD,
        S_DIV_INIT,
        S_DIV_STEP,
        S_NORM_WR,
        S_SUM_START,
        S_SUM_ISSUE,
        S_SUM_DRAIN,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_stale, n_stale;
    logic                r_out_valid, n_out_valid;
    t_dp_op              w_op;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_step      = r_step;
        n_stale     = r_stale | i_cfg_touch;
        n_out_valid = r_out_valid & ~i_out_ready;
        w_op        = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = OP_LOAD_ITEM;
                    n_state = r_stale ? S_RC_CLEAR : S_SUM_START;
                end
            end
            S_RC_CLEAR: begin
                w_op    = OP_RC_CLEAR;
                n_stale = 1'b0;
                n_idx   = '0;
                n_state = S_RC_RAW;
            end
            S_RC_RAW: begin
                if (i_st.direct) begin
                    w_op = OP_RAW_DIRECT;
                    if (i_st.last) begin
                        n_idx   = '0;
                        n_state = S_NORM_RD;
                    end else begin
                        n_idx = IDX_W'(r_idx + 1'b1);
                    end
                end else begin
                    n_state = S_LOG_INIT;
                end
            end
            S_LOG_INIT: begin
                w_op    = OP_LOG_INIT;
                n_step  = '0;
                n_state = S_LOG_STEP;
            end
            S_LOG_STEP: begin
                w_op = OP_LOG_STEP;
                if (r_step == STEP_W'(LOG_LAST)) begin
                    n_state = S_VMUL;
                end else begin
                    n_step = STEP_W'(r_step + 1'b1);
                end
            end
            S_VMUL: begin
                w_op    = OP_VMUL;
                n_step  = STEP_W'(1);
                n_state = S_POW_STEP;
            end
            S_POW_STEP: begin
                w_op = OP_POW_STEP;
                if (r_step == STEP_W'(POW_LAST)) begin
                    n_state = S_POW_FIN;
                end else begin
                    n_step = STEP_W'(r_step + 1'b1);
                end
            end
            S_POW_FIN: begin
                w_op = OP_POW_FIN;
                if (i_st.last) begin
                    n_idx   = '0;
                    n_state = S_NORM_RD;
                end else begin
                    n_idx   = IDX_W'(r_idx + 1'b1);
                    n_state = S_RC_RAW;
                end
            end
            S_NORM_RD: begin
                w_op    = OP_NORM_RD;
                n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                w_op    = OP_DIV_INIT;
                n_step  = '0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                w_op = OP_DIV_STEP;
                if (r_step == STEP_W'(DIV_LAST)) begin
                    n_state = S_NORM_WR;
                end else begin
                    n_step = STEP_W'(r_step + 1'b1);
                end
            end
            S_NORM_WR: begin
                w_op = OP_NORM_WR;
                if (i_st.last) begin
                    n_state = S_SUM_START;
                end else begin
                    n_idx   = IDX_W'(r_idx + 1'b1);
                    n_state = S_NORM_RD;
                end
            end
            S_SUM_START: begin
                w_op    = OP_SUM_START;
                n_idx   = '0;
                n_state = S_SUM_ISSUE;
            end
            S_SUM_ISSUE: begin
                w_op = OP_SUM_ISSUE;
                if (i_st.last) begin
                    n_state = S_SUM_DRAIN;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            S_SUM_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_op        = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_step      <= '0;
            r_stale     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_stale     <= n_stale;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = w_op;
    assign o_cmd.idx   = r_idx;
    assign o_cmd.step  = r_step;

endmodule

`default_nettype wire

// ===== hw/rtl/aho_dp.sv =====
// Datapath of the additive harmonic oscillator: configuration registers, log2 and exp2
// iteration, normalizing divider, raw and amplitude memories, sine table and the summing
// pipeline. Depends on aho_pkg.
`default_nettype none

module aho_dp
    import aho_pkg::*;
#(
    parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
    parameter int SINE_ENTRIES  = SINE_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_st,
    input  wire logic               i_cfg_wr,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [13:0]        i_cfg_data,
    input  wire logic [31:0]        i_phase_step,
    output logic signed [15:0]      o_sample_out
);

    localparam int IW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int HW = $clog2(MAX_HARMONICS + 1);
    localparam int SW = $clog2(SINE_ENTRIES);
    localparam int TW = 31 + IW;
    localparam int AW = 33 + IW;
    localparam int NW = TW + 17;
    localparam logic [30:0] ONE31 = 31'(Q30_ONE);
    localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO = AW'(-32768);

    logic [6:0]             r_count;
    logic [1:0]             r_mode;
    logic signed [13:0]     r_falloff;
    logic [31:0]            r_phase;
    logic [31:0]            r_step;

    logic [30:0]            r_m;
    logic [19:0]            r_res;
    logic [22:0]            r_v;
    logic [30:0]            r_w;
    logic [TW-1:0]          r_total;
    logic [30:0]            r_raw_q;
    logic [TW-1:0]          r_rem;
    logic [16:0]            r_divn;
    logic [16:0]            r_q;

    logic [31:0]            r_hpg;
    logic                   r_v1, r_v2, r_v3;
    logic [SW-1:0]          r_sidx;
    logic [15:0]            r_amp, r_amp1;
    logic signed [15:0]     r_sine;
    logic signed [32:0]     r_prod;
    logic signed [AW-1:0]   r_acc;
    logic signed [15:0]     r_sample;

    logic [30:0]            raw_mem [MAX_HARMONICS];
    logic [15:0]            amp_mem [MAX_HARMONICS];
    logic signed [15:0]     w_rom [SINE_ENTRIES];
    logic [30:0]            w_ef [EF_COUNT];

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
        localparam longint unsigned PH = (64'(g) << 32) / SINE_ENTRIES;
        assign w_rom[g] = sine_q15(PH);
    end

    for (genvar g = 0; g < EF_COUNT; g++) begin : g_ef
        assign w_ef[g] = ef_q30(g);
    end

    logic [IW-1:0]          idx;
    logic [HW-1:0]          n_eff;
    logic [HW-1:0]          h;
    logic [8:0]             cnt9;
    logic [1:0]             mode_eff;
    logic signed [13:0]     f_sat;
    logic [12:0]            mag;
    logic                   on;
    logic                   last;
    logic                   direct;
    logic [30:0]            raw_direct;
    logic [HW-1:0]          d;
    logic [3:0]             k;
    logic [61:0]            sq;
    logic [31:0]            sqt;
    logic [14:0]            mag3;
    logic [34:0]            vp;
    logic [61:0]            wp;
    logic [6:0]             kk;
    logic [30:0]            raw_pow;
    logic [NW-1:0]          nval;
    logic [TW:0]            rem2;
    logic [15:0]            wnorm;
    logic [63:0]            ip;
    logic signed [AW-1:0]   rnd;
    logic signed [AW-1:0]   shv;
    logic signed [15:0]     sat;

    always_comb begin
        idx  = i_cmd.idx[IW-1:0];
        cnt9 = {2'b00, r_count};
        if (cnt9 == 9'd0) begin
            n_eff = HW'(1);
        end else if (cnt9 > 9'(MAX_HARMONICS)) begin
            n_eff = HW'(MAX_HARMONICS);
        end else begin
            n_eff = HW'(cnt9);
        end
        h        = HW'(HW'(idx) + 1'b1);
        last     = (h == n_eff);
        mode_eff = (r_mode == 2'd3) ? MODE_EVEN : r_mode;
        if (r_falloff > 14'sd4096) begin
            f_sat = 14'sd4096;
        end else if (r_falloff < -14'sd4096) begin
            f_sat = -14'sd4096;
        end else begin
            f_sat = r_falloff;
        end
        mag = f_sat[13] ? 13'(-f_sat) : 13'(f_sat);
        on  = (mode_eff == MODE_ALL) || (idx == '0)
              || ((mode_eff == MODE_ODD) ? !idx[0] : idx[0]);
        direct = !on || (f_sat == 14'sd4096) || (f_sat == -14'sd4096) || (f_sat == 14'sd0);
        if (!on) begin
            raw_direct = '0;
        end else if (f_sat == -14'sd4096) begin
            raw_direct = (idx == '0) ? ONE31 : '0;
        end else if (f_sat == 14'sd4096) begin
            raw_direct = last ? ONE31 : '0;
        end else begin
            raw_direct = ONE31;
        end
        d = f_sat[13] ? h : HW'(n_eff - HW'(idx));
        k = '0;
        for (int b = 0; b < HW; b++) begin
            if (d[b]) begin
                k = 4'(b);
            end
        end
        sq      = r_m * r_m;
        sqt     = sq[61:30];
        mag3    = 15'(mag) * 15'd3;
        vp      = mag3 * r_res;
        wp      = r_w * w_ef[i_cmd.step];
        kk      = r_v[22:16];
        raw_pow = (kk >= 7'd31) ? '0 : (r_w >> kk);
        nval    = (NW'(r_raw_q) << 16) + NW'(r_total >> 1);
        rem2    = {r_rem, r_divn[16]};
        if (r_total == '0) begin
            wnorm = '0;
        end else if (r_q > 17'd65535) begin
            wnorm = 16'hFFFF;
        end else begin
            wnorm = r_q[15:0];
        end
        ip  = 64'(r_hpg) * 64'(SINE_ENTRIES);
        rnd = r_acc + AW'(32768);
        shv = rnd >>> 16;
        if (shv > SAT_HI) begin
            sat = 16'sh7FFF;
        end else if (shv < SAT_LO) begin
            sat = -16'sh8000;
        end else begin
            sat = 16'(shv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 7'd8;
            r_mode    <= MODE_ALL;
            r_falloff <= '0;
            r_phase   <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_HARMONIC_COUNT: r_count   <= i_cfg_data[6:0];
                    CFG_HARMONIC_MODE:  r_mode    <= i_cfg_data[1:0];
                    CFG_FALLOFF:        r_falloff <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_FINISH) begin
                r_phase <= r_phase + r_step;
            end
            r_v1 <= (i_cmd.op == OP_SUM_ISSUE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw_q <= raw_mem[idx];
        r_amp   <= amp_mem[idx];
        r_sine  <= w_rom[r_sidx];
        r_amp1  <= r_amp;
        r_prod  <= r_sine * $signed({1'b0, r_amp1});
        if (r_v3) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        case (i_cmd.op)
            OP_LOAD_ITEM: r_step <= i_phase_step;
            OP_RC_CLEAR:  r_total <= '0;
            OP_RAW_DIRECT: begin
                raw_mem[idx] <= raw_direct;
                r_total      <= r_total + TW'(raw_direct);
            end
            OP_LOG_INIT: begin
                r_m   <= 31'(d) << (5'd30 - 5'(k));
                r_res <= {k, 16'h0000};
            end
            OP_LOG_STEP: begin
                if (sqt[31]) begin
                    r_m <= sqt[31:1];
                    r_res[4'(5'd15 - i_cmd.step)] <= 1'b1;
                end else begin
                    r_m <= sqt[30:0];
                end
            end
            OP_VMUL: begin
                r_v <= vp[34:12];
                r_w <= ONE31;
            end
            OP_POW_STEP: begin
                if (r_v[4'(5'd16 - i_cmd.step)]) begin
                    r_w <= wp[60:30];
                end
            end
            OP_POW_FIN: begin
                raw_mem[idx] <= raw_pow;
                r_total      <= r_total + TW'(raw_pow);
            end
            OP_DIV_INIT: begin
                r_rem  <= TW'(nval >> 17);
                r_divn <= nval[16:0];
                r_q    <= '0;
            end
            OP_DIV_STEP: begin
                r_divn <= {r_divn[15:0], 1'b0};
                if (rem2 >= {1'b0, r_total}) begin
                    r_rem <= TW'(rem2 - {1'b0, r_total});
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= rem2[TW-1:0];
                    r_q   <= {r_q[15:0], 1'b0};
                end
            end
            OP_NORM_WR: amp_mem[idx] <= wnorm;
            OP_SUM_START: begin
                r_hpg <= r_phase;
                r_acc <= '0;
            end
            OP_SUM_ISSUE: begin
                r_hpg  <= r_hpg + r_phase;
                r_sidx <= ip[SW+31:32];
            end
            OP_FINISH: r_sample <= sat;
            default: ;
        endcase
    end

    assign o_st.direct    = direct;
    assign o_st.last      = last;
    assign o_st.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_sample_out   = r_sample;

endmodule

`default_nettype wire

// ===== hw/rtl/additive_harmonic_oscillator.sv =====
// Additive harmonic oscillator top level: controller, datapath and configuration port.
// An item is summed one harmonic per cycle through the sine table pipeline, and the
// block takes one item at a time. The first item after reset or a write to the count,
// mode or falloff register first recomputes the amplitudes: log2 and exp2 iterations
// per weighted harmonic, a direct write per masked or exact one, then the normalizing
// divider per harmonic. Reset is synchronous, active low.
`default_nettype none

module additive_harmonic_oscillator
    import aho_pkg::*;
#(
    parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
    parameter int SINE_ENTRIES  = SINE_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [31:0]        i_phase_step,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_sample_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [13:0]        i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_st;
    logic       w_cfg_wr;
    logic       w_cfg_touch;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_cfg_touch = w_cfg_wr && ((i_cfg_index == CFG_HARMONIC_COUNT)
                         || (i_cfg_index == CFG_HARMONIC_MODE)
                         || (i_cfg_index == CFG_FALLOFF));

    aho_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_touch (w_cfg_touch),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    aho_dp #(
        .MAX_HARMONICS (MAX_HARMONICS),
        .SINE_ENTRIES  (SINE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_st         (w_st),
        .i_cfg_wr     (w_cfg_wr),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_phase_step (i_phase_step),
        .o_sample_out (o_sample_out)
    );

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_st.pipe_busy)
        else $error("summing pipeline busy while idle");

    a_issue_fills_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_SUM_ISSUE) |=> w_st.pipe_busy)
        else $error("harmonic issue did not enter the pipeline");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted without leaving idle");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the additive harmonic oscillator: directed rows, then random samples,
// all checked against a predictor of the sine sum and the amplitude weights.
// Depends on aho_pkg and additive_harmonic_oscillator.
`timescale 1ns / 1ps

module tb_top;
    import aho_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;
    localparam int          N_RANDOM    = 430;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [31:0]        i_phase_step = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_sample_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [13:0]        i_cfg_data = '0;

    additive_harmonic_oscillator u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state.
    logic signed [15:0] sine_tab [SINE_ENTRIES_DEF];
    longint unsigned    exp_fac [EF_COUNT];
    logic [15:0]        amp [MAX_HARMONICS_DEF];
    logic [6:0]         reg_count = 7'd8;
    logic [1:0]         reg_mode = MODE_ALL;
    logic [13:0]        reg_falloff = '0;
    logic [31:0]        phase = '0;
    bit                 amps_stale = 1'b1;

    logic signed [15:0] sample_q [$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 no_idle = 1'b0;
    int                 stall_left = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root, b, rem;
        root = 0;
        rem  = v;
        b    = 64'd1 << 62;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [15:0] quarter_sine(input longint unsigned t);
        longint unsigned r, x, x2, s, q;
        r = t & 64'h3FFF_FFFF;
        if (t[30]) r = Q30_ONE - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        s  = Q30_ONE - x2 / 110;
        s  = Q30_ONE - ((x2 * s) >> 30) / 72;
        s  = Q30_ONE - ((x2 * s) >> 30) / 42;
        s  = Q30_ONE - ((x2 * s) >> 30) / 20;
        s  = Q30_ONE - ((x2 * s) >> 30) / 6;
        s  = (x * s) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767) q = 64'd32767;
        return t[31] ? -$signed(16'(q)) : $signed(16'(q));
    endfunction

    function automatic longint unsigned log2_fixed(input int unsigned d);
        int unsigned     k;
        longint unsigned m, res;
        k = 0;
        while (k < 31 && (d >> (k + 1)) != 0) k++;
        m   = longint'(d) << (30 - k);
        res = longint'(k) << 16;
        for (int j = 0; j < 16; j++) begin
            m = (m * m) >> 30;
            if (m >= (Q30_ONE << 1)) begin
                m = m >> 1;
                res = res | (64'd1 << (15 - j));
            end
        end
        return res;
    endfunction

    function automatic longint unsigned exp2_neg(input longint unsigned v);
        longint unsigned w, k;
        w = Q30_ONE;
        k = v >> 16;
        for (int j = 1; j <= 16; j++) begin
            if ((v >> (16 - j)) & 1) w = (w * exp_fac[j]) >> 30;
        end
        return (k >= 31) ? 64'd0 : (w >> k);
    endfunction

    function automatic void update_weights();
        longint unsigned raw [MAX_HARMONICS_DEF];
        longint unsigned total, r, w;
        int              n, f, mag, h, d;
        logic [1:0]      mode;
        bit              on;
        total = 0;
        n = (reg_count < 1) ? 1 : (reg_count > MAX_HARMONICS_DEF) ? MAX_HARMONICS_DEF
                                                                  : int'(reg_count);
        mode = (reg_mode > MODE_EVEN) ? MODE_EVEN : reg_mode;
        f = int'($signed(reg_falloff));
        if (f > 4096) f = 4096;
        if (f < -4096) f = -4096;
        mag = (f < 0) ? -f : f;
        for (int i = 0; i < MAX_HARMONICS_DEF; i++) begin
            h = i + 1;
            raw[i] = 0;
            if (i < n) begin
                on = (mode == MODE_ALL) || (i == 0) ||
                     ((mode == MODE_ODD) ? (h % 2 == 1) : (h % 2 == 0));
                if (f == -4096) r = (i == 0) ? Q30_ONE : 0;
                else if (f == 4096) r = (i == n - 1) ? Q30_ONE : 0;
                else if (f == 0) r = Q30_ONE;
                else begin
                    d = (f < 0) ? h : (n - i);
                    r = exp2_neg((longint'(3 * mag) * log2_fixed(d)) >> 12);
                end
                raw[i] = on ? r : 0;
                total += raw[i];
            end
        end
        for (int i = 0; i < MAX_HARMONICS_DEF; i++) begin
            w = 0;
            if (total != 0) begin
                w = ((raw[i] << 16) + total / 2) / total;
                if (w > 65535) w = 65535;
            end
            amp[i] = w[15:0];
        end
    endfunction

    function automatic logic signed [15:0] next_sample(input logic [31:0] step);
        longint     acc, q;
        int         n;
        logic [31:0] hp;
        if (amps_stale) begin
            update_weights();
            amps_stale = 1'b0;
        end
        n = (reg_count < 1) ? 1 : (reg_count > MAX_HARMONICS_DEF) ? MAX_HARMONICS_DEF
                                                                  : int'(reg_count);
        acc = 0;
        for (int h = 1; h <= n; h++) begin
            hp  = 32'(longint'(phase) * h);
            acc += longint'(sine_tab[hp >> 20]) * longint'({1'b0, amp[h - 1]});
        end
        q = (acc + 32768) >>> 16;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        phase = phase + step;
        return q[15:0];
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_tick(input logic [31:0] step, input bit chk, input logic [15:0] exp_v);
        logic signed [15:0] p;
        int g;
        i_in_valid   <= 1'b1;
        i_phase_step <= step;
        do @(posedge i_clk); while (!o_in_ready);
        p = next_sample(step);
        if (chk && p !== exp_v) begin
            $display("%0t: predictor disagrees with table: expected %0d, predicted %0d",
                     $realtime, $signed(exp_v), p);
            errors++;
        end
        sample_q.push_back(chk ? $signed(exp_v) : p);
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HARMONIC_COUNT: reg_count = data[6:0];
            CFG_HARMONIC_MODE:  reg_mode = data[1:0];
            CFG_FALLOFF:        reg_falloff = data;
            default: ;
        endcase
        if (idx != CFG_UNUSED) amps_stale = 1'b1;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [13:0] data;
        logic [31:0] step;
        bit          chk;
        logic [15:0] exp_v;
    } t_row;

    t_row rows [] = '{
        '{0, 0, 0, 32'h0000_0000, 1, 16'd0},
        '{0, 0, 0, 32'hFFFF_FFFF, 1, 16'd0},
        '{0, 0, 0, 32'h8000_0000, 0, 0},
        '{0, 0, 0, 32'h0000_0001, 0, 0},
        '{0, 0, 0, 32'h4000_0000, 0, 0},
        '{0, 0, 0, 32'h1234_5678, 0, 0},
        '{1, CFG_HARMONIC_COUNT, 14'd1, 0, 0, 0},
        '{0, 0, 0, 32'h0100_0000, 0, 0},
        '{0, 0, 0, 32'h0000_0000, 0, 0},
        '{1, CFG_FALLOFF, 14'h3000, 0, 0, 0},
        '{1, CFG_HARMONIC_COUNT, 14'd8, 0, 0, 0},
        '{0, 0, 0, 32'h0555_5555, 0, 0},
        '{1, CFG_FALLOFF, 14'd4096, 0, 0, 0},
        '{0, 0, 0, 32'h0AAA_AAAA, 0, 0},
        '{1, CFG_HARMONIC_MODE, MODE_ODD, 0, 0, 0},
        '{0, 0, 0, 32'h0777_0000, 1, 16'd0},
        '{0, 0, 0, 32'hF000_0001, 1, 16'd0},
        '{1, CFG_FALLOFF, 14'h1FFF, 0, 0, 0},
        '{1, CFG_HARMONIC_MODE, 14'h3FFF, 0, 0, 0},
        '{0, 0, 0, 32'h0321_0FED, 0, 0},
        '{1, CFG_FALLOFF, 14'h2000, 0, 0, 0},
        '{1, CFG_HARMONIC_COUNT, 14'h3F80, 0, 0, 0},
        '{0, 0, 0, 32'h00FF_FF00, 0, 0},
        '{1, CFG_HARMONIC_COUNT, 14'd127, 0, 0, 0},
        '{1, CFG_UNUSED, 14'h3FFF, 0, 0, 0},
        '{0, 0, 0, 32'h0400_0003, 0, 0},
        '{1, CFG_FALLOFF, 14'h3F01, 0, 0, 0},
        '{0, 0, 0, 32'h0123_4567, 0, 0}
    };

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (sample_q.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, actual %0d",
                             $realtime, o_sample_out);
                    errors++;
                end else begin
                    if (o_sample_out !== sample_q[0]) begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $realtime, sample_q[0], o_sample_out);
                        errors++;
                    end
                    void'(sample_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0) begin
                    stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 3);
                end
            end
        end
    end

    initial begin
        int          sent;
        int          burst;
        int          r;
        logic [31:0] step;
        logic [31:0] base;
        exp_fac[0] = Q30_ONE >> 1;
        for (int i = 1; i < EF_COUNT; i++) exp_fac[i] = int_sqrt(exp_fac[i - 1] << 30);
        for (int i = 0; i < SINE_ENTRIES_DEF; i++) sine_tab[i] = quarter_sine(longint'(i) << 20);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_idle();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_tick(rows[i].step, rows[i].chk, rows[i].exp_v);
            end
        end

        sent = 0;
        while (sent < N_RANDOM) begin
            wait_idle();
            no_idle = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            write_reg(CFG_HARMONIC_COUNT,
                      (r == 0) ? 14'($urandom) : (r == 1) ? 14'(64) : 14'($urandom_range(1, 16)));
            write_reg(CFG_HARMONIC_MODE, 14'($urandom_range(0, 3)));
            r = $urandom_range(0, 9);
            write_reg(CFG_FALLOFF, (r == 0) ? 14'd4096 : (r == 1) ? 14'h3000 :
                                   (r == 2) ? 14'd0 : (r == 3) ? 14'($urandom) :
                                   14'($urandom_range(0, 8192) - 4096));
            burst = $urandom_range(10, 40);
            base  = $urandom;
            for (int k = 0; k < burst; k++) begin
                step = ($urandom_range(0, 3) == 0) ? $urandom : base;
                send_tick(step, 1'b0, '0);
            end
            sent += burst;
        end

        i_in_valid <= 1'b0;
        no_idle = 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/aho_pkg.sv
hw/rtl/aho_ctrl.sv
hw/rtl/aho_dp.sv
hw/rtl/additive_harmonic_oscillator.sv
tb/sv/tb_top.sv
